// ===== sv/pidaw_pkg.sv =====
// ----------------------------------------------------------------------------
// pidaw_pkg: shared types and microcode for the PID step block
// Holds register indexes, control word layout and the sequencer program.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  // Field and register widths
  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int DT_W          = 16;
  localparam int LIMIT_W       = 31;
  localparam int CFG_IDX_W     = 2;
  localparam int STEP_W        = 4;

  // Register reset values
  localparam logic [DATA_W-1:0]  GAIN_PROP_RST   = 32'd5243;
  localparam logic [DATA_W-1:0]  GAIN_INTEG_RST  = 32'd786;
  localparam logic [DATA_W-1:0]  GAIN_DERIV_RST  = 32'd524;
  localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 31'd3276800;

  // Saturation bounds
  localparam logic [DATA_W-1:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP,
    CFG_GAIN_INTEG,
    CFG_GAIN_DERIV,
    CFG_INTEG_LIMIT
  } cfg_idx_e;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_E_DT,
    MUL_KP_E,
    MUL_KI_I,
    MUL_KD_D
  } mul_sel_e;

  // Datapath operation of one step
  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_TAKE,
    ALU_CLEAR,
    ALU_INTEG,
    ALU_ACC_LOAD,
    ALU_ACC_ADD,
    ALU_DIV_START,
    ALU_DIV_STEP,
    ALU_DERIV,
    ALU_OUT
  } alu_op_e;

  // Sequencing of one step
  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_WAIT_IN,
    C_IF_CLEAR,
    C_LOOP_DIV,
    C_WAIT_OUT
  } cond_e;

  typedef struct packed {
    mul_sel_e          mul;
    alu_op_e           alu;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } cw_t;

  // Control from sequencer to datapath
  typedef struct packed {
    cw_t  cw;
    logic fire;
  } ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic cmd_clear;
    logic div_last;
    logic out_busy;
  } stat_t;

  // Program addresses
  localparam logic [STEP_W-1:0] ST_WAIT  = 4'd0;
  localparam logic [STEP_W-1:0] ST_DIV   = 4'd5;
  localparam logic [STEP_W-1:0] ST_CLEAR = 4'd10;

  // Microcode ROM
  function automatic cw_t ucode(input logic [STEP_W-1:0] step);
    cw_t w;
    w = '{mul: MUL_NONE, alu: ALU_NOP, cond: C_GOTO, target: ST_WAIT};
    case (step)
      4'd0:  w = '{mul: MUL_NONE, alu: ALU_TAKE,      cond: C_WAIT_IN,  target: ST_WAIT};
      4'd1:  w = '{mul: MUL_E_DT, alu: ALU_DIV_START, cond: C_IF_CLEAR, target: ST_CLEAR};
      4'd2:  w = '{mul: MUL_KP_E, alu: ALU_INTEG,     cond: C_NEXT,     target: ST_WAIT};
      4'd3:  w = '{mul: MUL_KI_I, alu: ALU_ACC_LOAD,  cond: C_NEXT,     target: ST_WAIT};
      4'd4:  w = '{mul: MUL_NONE, alu: ALU_ACC_ADD,   cond: C_NEXT,     target: ST_WAIT};
      4'd5:  w = '{mul: MUL_NONE, alu: ALU_DIV_STEP,  cond: C_LOOP_DIV, target: ST_DIV};
      4'd6:  w = '{mul: MUL_NONE, alu: ALU_DERIV,     cond: C_NEXT,     target: ST_WAIT};
      4'd7:  w = '{mul: MUL_KD_D, alu: ALU_NOP,       cond: C_NEXT,     target: ST_WAIT};
      4'd8:  w = '{mul: MUL_NONE, alu: ALU_ACC_ADD,   cond: C_NEXT,     target: ST_WAIT};
      4'd9:  w = '{mul: MUL_NONE, alu: ALU_OUT,       cond: C_WAIT_OUT, target: ST_WAIT};
      4'd10: w = '{mul: MUL_NONE, alu: ALU_CLEAR,     cond: C_GOTO,     target: ST_WAIT};
      default: w = '{mul: MUL_NONE, alu: ALU_NOP, cond: C_GOTO, target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/pidaw_useq.sv =====
// ----------------------------------------------------------------------------
// pidaw_useq: microcode sequencer
// Steps through the control ROM, handles waits and conditional jumps.
// ----------------------------------------------------------------------------
module pidaw_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pidaw_pkg::stat_t  stat_i,
  output pidaw_pkg::ctrl_t  ctrl_o
);

  logic [pidaw_pkg::STEP_W-1:0] step_q, step_d, step_inc;
  pidaw_pkg::cw_t               cw;
  logic                         accept;

  // Fetch the control word of the current step
  assign cw       = pidaw_pkg::ucode(step_q);
  assign step_inc = step_q + pidaw_pkg::STEP_W'(1);

  assign in_stall_o = (cw.cond != pidaw_pkg::C_WAIT_IN);
  assign accept     = in_valid_i && (cw.cond == pidaw_pkg::C_WAIT_IN);

  // Gate datapath effects on wait steps
  always_comb begin
    ctrl_o.cw = cw;
    case (cw.cond)
      pidaw_pkg::C_WAIT_IN:  ctrl_o.fire = accept;
      pidaw_pkg::C_WAIT_OUT: ctrl_o.fire = !stat_i.out_busy;
      default:               ctrl_o.fire = 1'b1;
    endcase
  end

  // Select the next step
  always_comb begin
    case (cw.cond)
      pidaw_pkg::C_NEXT:     step_d = step_inc;
      pidaw_pkg::C_GOTO:     step_d = cw.target;
      pidaw_pkg::C_WAIT_IN:  step_d = accept ? step_inc : step_q;
      pidaw_pkg::C_IF_CLEAR: step_d = stat_i.cmd_clear ? cw.target : step_inc;
      pidaw_pkg::C_LOOP_DIV: step_d = stat_i.div_last ? step_inc : cw.target;
      pidaw_pkg::C_WAIT_OUT: step_d = stat_i.out_busy ? step_q : cw.target;
      default:               step_d = pidaw_pkg::ST_WAIT;
    endcase
  end

  // Hold the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= pidaw_pkg::ST_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== sv/pidaw_dpath.sv =====
// ----------------------------------------------------------------------------
// pidaw_dpath: PID datapath
// Registers, one shared multiplier, a radix-2 divider and the output stage.
// ----------------------------------------------------------------------------
module pidaw_dpath #(
  parameter int FRAC_BITS = pidaw_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pidaw_pkg::DATA_W-1:0]      cfg_data_i,
  input  logic                              command_i,
  input  logic signed [pidaw_pkg::DATA_W-1:0] error_in_i,
  input  logic [pidaw_pkg::DT_W-1:0]        dt_step_i,
  input  pidaw_pkg::ctrl_t                  ctrl_i,
  output pidaw_pkg::stat_t                  stat_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic signed [pidaw_pkg::DATA_W-1:0] drive_o
);

  localparam int DW     = pidaw_pkg::DATA_W;
  localparam int TW     = pidaw_pkg::DT_W;
  localparam int ACC_W  = 2 * DW + 2 - FRAC_BITS;
  localparam int NUM_W  = DW + FRAC_BITS;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int DT_MIN = ((1 << FRAC_BITS) + 999) / 1000;
  localparam int DT_MAX = (1 << FRAC_BITS) / 5;
  localparam logic [NUM_W-1:0] Q_MIN_MAG = NUM_W'(64'h8000_0000);

  // Configuration and controller state
  logic signed [DW-1:0]          kp_q, kp_d, ki_q, ki_d, kd_q, kd_d;
  logic [pidaw_pkg::LIMIT_W-1:0] lim_q, lim_d;
  logic signed [DW-1:0]          integ_q, integ_d, last_q, last_d;
  logic                          first_q, first_d;
  logic                          out_valid_q, out_valid_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;

  // Working registers
  logic                          cmd_q, cmd_d;
  logic signed [DW-1:0]          e_q, e_d, deriv_q, deriv_d, drive_q, drive_d;
  logic [TW-1:0]                 dt_q, dt_d, dt_c;
  logic signed [2*DW-1:0]        prod_q, prod_d;
  logic signed [ACC_W-1:0]       acc_q, acc_d;
  logic [TW-1:0]                 rem_q, rem_d;
  logic [NUM_W-1:0]              quo_q, quo_d;
  logic                          neg_q, neg_d;

  // Combinational helpers
  logic signed [DW-1:0]          mul_a, mul_b;
  logic signed [2*DW-1:0]        mul_p;
  logic signed [ACC_W-1:0]       term, integ_sum, lim_pos, lim_neg;
  logic signed [DW:0]            diff;
  logic [DW-1:0]                 mag;
  logic [TW:0]                   trial, trial_sub;
  logic                          trial_ge;
  logic [NUM_W-1:0]              quo_neg;
  logic                          acc_fits;
  pidaw_pkg::alu_op_e            op;

  assign op = ctrl_i.fire ? ctrl_i.cw.alu : pidaw_pkg::ALU_NOP;

  // Clamp the time step
  always_comb begin
    if (32'(dt_step_i) < 32'(DT_MIN)) begin
      dt_c = TW'(DT_MIN);
    end else if (32'(dt_step_i) > 32'(DT_MAX)) begin
      dt_c = TW'(DT_MAX);
    end else begin
      dt_c = dt_step_i;
    end
  end

  // Select multiplier operands
  always_comb begin
    case (ctrl_i.cw.mul)
      pidaw_pkg::MUL_E_DT: begin
        mul_a = e_q;
        mul_b = $signed(DW'(dt_q));
      end
      pidaw_pkg::MUL_KP_E: begin
        mul_a = kp_q;
        mul_b = e_q;
      end
      pidaw_pkg::MUL_KI_I: begin
        mul_a = ki_q;
        mul_b = integ_q;
      end
      pidaw_pkg::MUL_KD_D: begin
        mul_a = kd_q;
        mul_b = deriv_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Floor of the registered product in fixed point
  assign term      = ACC_W'(prod_q >>> FRAC_BITS);
  assign integ_sum = ACC_W'(integ_q) + term;
  assign lim_pos   = $signed(ACC_W'(lim_q));
  assign lim_neg   = -lim_pos;

  // Divider operands
  assign diff      = $signed({e_q[DW-1], e_q}) - $signed({last_q[DW-1], last_q});
  assign mag       = diff[DW] ? DW'(-diff) : diff[DW-1:0];
  assign trial     = {rem_q, quo_q[NUM_W-1]};
  assign trial_sub = trial - {1'b0, dt_q};
  assign trial_ge  = (trial >= {1'b0, dt_q});
  assign quo_neg   = ~quo_q + NUM_W'(1);

  // Sum fits in 32 bits when the upper bits are a sign extension
  assign acc_fits = (&acc_q[ACC_W-1:DW-1]) || !(|acc_q[ACC_W-1:DW-1]);

  // Next-state logic
  always_comb begin
    kp_d        = kp_q;
    ki_d        = ki_q;
    kd_d        = kd_q;
    lim_d       = lim_q;
    integ_d     = integ_q;
    last_d      = last_q;
    first_d     = first_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    e_d         = e_q;
    dt_d        = dt_q;
    deriv_d     = deriv_q;
    drive_d     = drive_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && out_stall_i;

    // Write configuration registers
    if (cfg_we_i) begin
      case (pidaw_pkg::cfg_idx_e'(cfg_idx_i))
        pidaw_pkg::CFG_GAIN_PROP:   kp_d  = $signed(cfg_data_i);
        pidaw_pkg::CFG_GAIN_INTEG:  ki_d  = $signed(cfg_data_i);
        pidaw_pkg::CFG_GAIN_DERIV:  kd_d  = $signed(cfg_data_i);
        pidaw_pkg::CFG_INTEG_LIMIT: lim_d = cfg_data_i[pidaw_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end

    // Register the product
    if (ctrl_i.fire && (ctrl_i.cw.mul != pidaw_pkg::MUL_NONE)) begin
      prod_d = mul_p;
    end

    case (op)
      pidaw_pkg::ALU_TAKE: begin
        cmd_d = command_i;
        e_d   = error_in_i;
        dt_d  = dt_c;
      end
      pidaw_pkg::ALU_CLEAR: begin
        integ_d = '0;
        last_d  = '0;
        first_d = 1'b1;
      end
      pidaw_pkg::ALU_INTEG: begin
        if (integ_sum > lim_pos) begin
          integ_d = DW'(lim_pos);
        end else if (integ_sum < lim_neg) begin
          integ_d = DW'(lim_neg);
        end else begin
          integ_d = DW'(integ_sum);
        end
      end
      pidaw_pkg::ALU_ACC_LOAD: acc_d = term;
      pidaw_pkg::ALU_ACC_ADD:  acc_d = acc_q + term;
      pidaw_pkg::ALU_DIV_START: begin
        quo_d = {mag, {FRAC_BITS{1'b0}}};
        rem_d = '0;
        neg_d = diff[DW];
        cnt_d = CNT_W'(NUM_W);
      end
      pidaw_pkg::ALU_DIV_STEP: begin
        rem_d = trial_ge ? trial_sub[TW-1:0] : trial[TW-1:0];
        quo_d = {quo_q[NUM_W-2:0], trial_ge};
        cnt_d = cnt_q - CNT_W'(1);
      end
      pidaw_pkg::ALU_DERIV: begin
        // Zero on the first sample, else saturate the truncated quotient
        if (first_q) begin
          deriv_d = '0;
        end else if (!neg_q) begin
          deriv_d = (|quo_q[NUM_W-1:DW-1]) ? $signed(pidaw_pkg::S32_MAX)
                                           : $signed(quo_q[DW-1:0]);
        end else begin
          deriv_d = (quo_q > Q_MIN_MAG) ? $signed(pidaw_pkg::S32_MIN)
                                        : $signed(quo_neg[DW-1:0]);
        end
        last_d  = e_q;
        first_d = 1'b0;
      end
      pidaw_pkg::ALU_OUT: begin
        if (acc_fits) begin
          drive_d = acc_q[DW-1:0];
        end else begin
          drive_d = acc_q[ACC_W-1] ? $signed(pidaw_pkg::S32_MIN)
                                   : $signed(pidaw_pkg::S32_MAX);
        end
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= pidaw_pkg::GAIN_PROP_RST;
      ki_q        <= pidaw_pkg::GAIN_INTEG_RST;
      kd_q        <= pidaw_pkg::GAIN_DERIV_RST;
      lim_q       <= pidaw_pkg::INTEG_LIMIT_RST;
      integ_q     <= '0;
      last_q      <= '0;
      first_q     <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      kp_q        <= kp_d;
      ki_q        <= ki_d;
      kd_q        <= kd_d;
      lim_q       <= lim_d;
      integ_q     <= integ_d;
      last_q      <= last_d;
      first_q     <= first_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    e_q     <= e_d;
    dt_q    <= dt_d;
    deriv_q <= deriv_d;
    drive_q <= drive_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    neg_q   <= neg_d;
    prod_q  <= prod_d;
  end

  assign stat_o.cmd_clear = cmd_q;
  assign stat_o.div_last  = (cnt_q == CNT_W'(1));
  assign stat_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule

// ===== sv/pid_step_anti_windup.sv =====
// ----------------------------------------------------------------------------
// pid_step_anti_windup: PID step with integral clamp, signed fixed point
// A microcoded sequencer drives a datapath with one shared multiplier and a
// one-bit-per-cycle divider for the derivative.
//
//   Port group   Direction  Handshake                  Payload
//   input item   in         in_valid_i / in_stall_o    command_i, error_in_i, dt_step_i
//   result item  out        out_valid_o / out_stall_i  drive_o
//   config       in         cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A new item is accepted only after the previous one has run its full program,
// divider loop included. A clear item gives no result.
// The result register holds one item; the block waits in its final step
// while that register is full and stalled.
// Reset loads the gain defaults, zeroes the integral and previous error and
// marks the next update as a first sample.
// ----------------------------------------------------------------------------
module pid_step_anti_windup #(
  parameter int FRAC_BITS = pidaw_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pidaw_pkg::DATA_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic signed [pidaw_pkg::DATA_W-1:0] error_in_i,
  input  logic [pidaw_pkg::DT_W-1:0]          dt_step_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pidaw_pkg::DATA_W-1:0] drive_o
);

  pidaw_pkg::ctrl_t ctrl;
  pidaw_pkg::stat_t stat;

  // Sequencer
  pidaw_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // Datapath
  pidaw_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .command_i   (command_i),
    .error_in_i  (error_in_i),
    .dt_step_i   (dt_step_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .drive_o     (drive_o)
  );

endmodule

// ===== sv/pidaw_chk.sv =====
// ----------------------------------------------------------------------------
// pidaw_chk: port checker for the PID step block
// Watches the top-level ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module pidaw_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                command_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [pidaw_pkg::DATA_W-1:0] drive_o
);

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // One item at a time: stall right after an accept
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input accepted on two consecutive cycles");

  // A clear item gives no result
  a_clear_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && command_i) |=> !$rose(out_valid_o))
    else $error("result raised right after a clear item");

  // A result never shows up in the cycle after an accept
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_acc))
    else $error("result raised too soon after an accepted item");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(drive_o)))
    else $error("stalled result dropped or changed");

endmodule

bind pid_step_anti_windup pidaw_chk u_pidaw_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .command_i   (command_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .drive_o     (drive_o)
);
